### hw/rtl/diagonal_gaussian_membership_test_macros.svh
// Assertion macros used by the RTL of the Gaussian membership test.
`ifndef DIAGONAL_GAUSSIAN_MEMBERSHIP_TEST_MACROS_SVH
`define DIAGONAL_GAUSSIAN_MEMBERSHIP_TEST_MACROS_SVH
`ifndef ASSERT_OFF
`define DGMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DGMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DGMT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DGMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/dgmt_pkg.sv
// Package with constants and types of the Gaussian membership test.
package dgmt_pkg;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // 15*ln2 + ln(2*pi) in Q.32: the log offset before any normalising shift.
  localparam logic signed [37:0] LOG_INIT = 38'sd52549288974;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MULD  = 9'b000000010,
    ST_DLOAD = 9'b000000100,
    ST_NORM  = 9'b000001000,
    ST_SQMUL = 9'b000010000,
    ST_SQNRM = 9'b000100000,
    ST_FMUL  = 9'b001000000,
    ST_FADD  = 9'b010000000,
    ST_TERM  = 9'b100000000
  } state_t;
endpackage

### hw/rtl/diagonal_gaussian_membership_test.sv
// Top level of the diagonal Gaussian membership test: sequencer, shared multiplier, divider.
// An input transfer is taken only in the idle state, so a dimension waits until the one
// before it is through; a held result can keep the sequencer in its term state.
// The variance takes up to 31 normalising shifts; the 32 squaring steps that follow, on the
// shared 32x32 multiplier, set the pace; the 64-step restoring divider runs alongside them.
// Synchronous active-low reset clears the sequencer, the score, the flag and the threshold.
`include "diagonal_gaussian_membership_test_macros.svh"
module diagonal_gaussian_membership_test (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic signed [47:0] cfg_score_threshold,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_mean_value,
  input  logic        [31:0] in_variance_value,
  input  logic               in_last_element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_log_likelihood,
  output logic               out_is_member,
  output logic               out_saturated
);

  dgmt_pkg::state_t state_r, state_nxt;

  logic signed [47:0] thr_r;
  logic signed [47:0] sum_r;
  logic               ovf_r;
  logic        [31:0] ad_r;
  logic        [31:0] var_r;
  logic               last_r;
  logic        [31:0] m_r;
  logic        [31:0] frac_r;
  logic        [4:0]  iter_r;
  logic signed [37:0] a_r;
  logic        [63:0] p_r;
  logic        [63:0] dq_r;
  logic        [31:0] rem_r;
  logic        [6:0]  div_cnt_r;
  logic               out_valid_r;
  logic signed [47:0] out_ll_r;
  logic               out_mem_r;
  logic               out_sat_r;

  logic               in_xfer;
  logic signed [32:0] diff;
  logic        [31:0] mul_a, mul_b;
  logic        [32:0] sq;
  logic        [32:0] rem_sh;
  logic               rem_ge;
  logic signed [37:0] a_rnd;
  logic signed [43:0] tq;
  logic signed [42:0] t_full;
  logic signed [31:0] term;
  logic               term_sat;
  logic signed [48:0] s_full;
  logic signed [47:0] s_clamp;
  logic               s_sat;
  logic               out_free;

  assign in_stall = (state_r != dgmt_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign diff     = 33'(in_x_value) - 33'(in_mean_value);
  assign out_free = !out_valid_r || !out_stall;

  // The one multiplier serves the squared difference, the squaring steps and
  // the scaling of the log fraction by ln 2.
  always_comb begin
    mul_a = ad_r;
    mul_b = ad_r;
    unique case (state_r)
      dgmt_pkg::ST_SQMUL: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      dgmt_pkg::ST_FMUL: begin
        mul_a = frac_r;
        mul_b = dgmt_pkg::LN2_Q32;
      end
      default: begin
        mul_a = ad_r;
        mul_b = ad_r;
      end
    endcase
  end

  assign sq     = p_r[63:31];
  assign rem_sh = {rem_r, dq_r[63]};
  assign rem_ge = (rem_sh >= {1'b0, var_r});

  // Term and sum, with rounding of the logarithm to Q16.16.
  always_comb begin
    a_rnd  = a_r + 38'sd32768;
    tq     = -44'($signed(a_rnd[37:16])) - $signed({3'b000, dq_r[40:0]});
    t_full = tq[43:1];
    term_sat = 1'b0;
    if (dq_r > 64'h0000_0100_0000_0000) begin
      term     = 32'sh8000_0000;
      term_sat = 1'b1;
    end else if (t_full > 43'sd2147483647) begin
      term     = 32'sh7fff_ffff;
      term_sat = 1'b1;
    end else if (t_full < -43'sd2147483648) begin
      term     = 32'sh8000_0000;
      term_sat = 1'b1;
    end else begin
      term = t_full[31:0];
    end
    s_full = 49'(sum_r) + 49'(term);
    s_sat  = 1'b0;
    if (s_full > 49'sh0_7fff_ffff_ffff) begin
      s_clamp = 48'sh7fff_ffff_ffff;
      s_sat   = 1'b1;
    end else if (s_full < -49'sh0_8000_0000_0000) begin
      s_clamp = 48'sh8000_0000_0000;
      s_sat   = 1'b1;
    end else begin
      s_clamp = s_full[47:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dgmt_pkg::ST_IDLE:  if (in_xfer) state_nxt = dgmt_pkg::ST_MULD;
      dgmt_pkg::ST_MULD:  state_nxt = dgmt_pkg::ST_DLOAD;
      dgmt_pkg::ST_DLOAD: state_nxt = dgmt_pkg::ST_NORM;
      dgmt_pkg::ST_NORM:  if (m_r[31]) state_nxt = dgmt_pkg::ST_SQMUL;
      dgmt_pkg::ST_SQMUL: state_nxt = dgmt_pkg::ST_SQNRM;
      dgmt_pkg::ST_SQNRM: begin
        if (iter_r == 5'd31) state_nxt = dgmt_pkg::ST_FMUL;
        else                 state_nxt = dgmt_pkg::ST_SQMUL;
      end
      dgmt_pkg::ST_FMUL:  state_nxt = dgmt_pkg::ST_FADD;
      dgmt_pkg::ST_FADD:  if (div_cnt_r == 7'd0) state_nxt = dgmt_pkg::ST_TERM;
      dgmt_pkg::ST_TERM:  if (!last_r || out_free) state_nxt = dgmt_pkg::ST_IDLE;
      default:            state_nxt = dgmt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dgmt_pkg::ST_IDLE;
      thr_r       <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) thr_r <= cfg_score_threshold;
      if (div_cnt_r != 7'd0) begin
        div_cnt_r <= div_cnt_r - 7'd1;
      end else if (state_r == dgmt_pkg::ST_DLOAD) begin
        div_cnt_r <= 7'd64;
      end
      // A new result may load in the same cycle as the held one is taken.
      if (state_r == dgmt_pkg::ST_TERM && last_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == dgmt_pkg::ST_TERM && (!last_r || out_free)) begin
        if (last_r) begin
          sum_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          sum_r <= s_clamp;
          ovf_r <= ovf_r | term_sat | s_sat;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (in_xfer) begin
      ad_r   <= diff[32] ? 32'(-diff) : diff[31:0];
      var_r  <= (in_variance_value == 32'd0) ? 32'd1 : in_variance_value;
      last_r <= in_last_element;
    end
    unique case (state_r)
      dgmt_pkg::ST_DLOAD: begin
        dq_r   <= p_r;
        rem_r  <= '0;
        m_r    <= var_r;
        a_r    <= dgmt_pkg::LOG_INIT;
        frac_r <= '0;
        iter_r <= '0;
      end
      dgmt_pkg::ST_NORM: begin
        if (!m_r[31]) begin
          m_r <= {m_r[30:0], 1'b0};
          a_r <= a_r - 38'($signed({1'b0, dgmt_pkg::LN2_Q32}));
        end
      end
      dgmt_pkg::ST_SQNRM: begin
        iter_r <= iter_r + 5'd1;
        m_r    <= sq[32] ? sq[32:1] : sq[31:0];
        frac_r <= {frac_r[30:0], sq[32]};
      end
      default: ;
    endcase
    if (state_r == dgmt_pkg::ST_FADD && iter_r == 5'd0) begin
      a_r    <= a_r + 38'($signed({1'b0, p_r[63:32]}));
      iter_r <= 5'd1;
    end
    // Restoring division, one quotient bit a cycle, alongside the logarithm.
    if (div_cnt_r != 7'd0) begin
      rem_r <= rem_ge ? 32'(rem_sh - {1'b0, var_r}) : rem_sh[31:0];
      dq_r  <= {dq_r[62:0], rem_ge};
    end
    if (state_r == dgmt_pkg::ST_TERM && last_r && out_free) begin
      out_ll_r  <= s_clamp;
      out_mem_r <= (s_clamp > thr_r);
      out_sat_r <= ovf_r | term_sat | s_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_log_likelihood = out_ll_r;
  assign out_is_member      = out_mem_r;
  assign out_saturated      = out_sat_r;

  `DGMT_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_xfer, state_r == dgmt_pkg::ST_MULD)
  `DGMT_ASSERT_IMPL(a_div_done, clk, rst_n, state_r == dgmt_pkg::ST_TERM, div_cnt_r == 7'd0)
  `DGMT_ASSERT_NEXT(a_result_from_term, clk, rst_n, !out_valid_r && state_r != dgmt_pkg::ST_TERM, !out_valid_r)

endmodule

### tb/tb_diagonal_gaussian_membership_test.sv
// Self-checking testbench for the diagonal Gaussian membership test.
`timescale 1ns / 100ps

module tb_diagonal_gaussian_membership_test;

  // Each vector is fed one dimension per transfer. A score model kept in the
  // testbench computes the expected summary for every vector, and each result
  // transfer is compared with the oldest waiting expectation.

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] mean_value;
    logic        [31:0] variance_value;
    logic               last_element;
  } dimension_t;

  typedef struct packed {
    logic signed [47:0] log_likelihood;
    logic               is_member;
    logic               saturated;
  } score_t;

  // A directed row may also carry a score typed in by hand, for cases that
  // can be read off without the model.
  typedef struct packed {
    dimension_t dim;
    logic       has_known;
    score_t     known;
  } directed_row_t;

  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam longint      LN2PI_Q32 = 64'sd7893621894;
  localparam longint      SUM_MAX   = 64'sd140737488355327;
  localparam longint      SUM_MIN   = -64'sd140737488355328;
  localparam longint      TERM_MAX  = 64'sd2147483647;
  localparam longint      TERM_MIN  = -64'sd2147483648;
  localparam int          RANDOM_ITEMS = 1650;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic signed [47:0] cfg_score_threshold;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_x_value;
  logic signed [31:0] in_mean_value;
  logic [31:0] in_variance_value;
  logic in_last_element;
  logic out_valid;
  logic out_stall;
  logic signed [47:0] out_log_likelihood;
  logic out_is_member;
  logic out_saturated;

  diagonal_gaussian_membership_test uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_score_threshold(cfg_score_threshold),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_x_value(in_x_value),
    .in_mean_value(in_mean_value),
    .in_variance_value(in_variance_value),
    .in_last_element(in_last_element),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_log_likelihood(out_log_likelihood),
    .out_is_member(out_is_member),
    .out_saturated(out_saturated)
  );

  // Score model state and the queue of scores still owed by the block.
  longint model_sum;
  bit     model_overflow;
  longint model_threshold;
  score_t pending_scores[$];
  int     failures;
  bit     stimulus_done;
  bit     long_hold_request;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic longint floor_half_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  // ln(2*pi*V) in Q16.16, rounded to nearest, using the squaring method.
  function automatic longint log_two_pi_var(logic [31:0] var_in);
    logic [31:0] v;
    int          k;
    logic [63:0] m;
    logic [63:0] frac;
    logic [127:0] prod;
    longint      a;
    v = (var_in == 32'd0) ? 32'd1 : var_in;
    k = 31;
    while (k > 0 && v[k] == 1'b0) k--;
    m = 64'(v) << (31 - k);
    frac = 64'd0;
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    prod = 128'(frac) * 128'(LN2_Q32);
    a = longint'(k - 16) * longint'(LN2_Q32) + longint'(prod >> 32) + LN2PI_Q32;
    return floor_half_div(a + 32768, 65536);
  endfunction

  // Adds one dimension to the model; returns 1 with the score on the last one.
  function automatic bit score_dimension(input dimension_t d, output score_t s);
    longint      diff;
    logic [63:0] abs_diff;
    logic [63:0] quad;
    logic [31:0] v;
    longint      lg;
    longint      term;
    longint      total;
    v = (d.variance_value == 32'd0) ? 32'd1 : d.variance_value;
    diff = longint'(d.x_value) - longint'(d.mean_value);
    abs_diff = (diff < 0) ? 64'(-diff) : 64'(diff);
    lg = log_two_pi_var(v);
    quad = (abs_diff * abs_diff) / 64'(v);
    if (quad > (64'd1 << 40)) begin
      term = TERM_MIN;
      model_overflow = 1'b1;
    end else begin
      term = floor_half_div(-lg - longint'(quad), 2);
      if (term > TERM_MAX) begin
        term = TERM_MAX;
        model_overflow = 1'b1;
      end else if (term < TERM_MIN) begin
        term = TERM_MIN;
        model_overflow = 1'b1;
      end
    end
    total = model_sum + term;
    if (total > SUM_MAX) begin
      total = SUM_MAX;
      model_overflow = 1'b1;
    end else if (total < SUM_MIN) begin
      total = SUM_MIN;
      model_overflow = 1'b1;
    end
    model_sum = total;
    s = '0;
    if (!d.last_element) return 1'b0;
    s.log_likelihood = model_sum[47:0];
    s.is_member = (model_sum > model_threshold);
    s.saturated = model_overflow;
    model_sum = 0;
    model_overflow = 1'b0;
    return 1'b1;
  endfunction

  // Drives one dimension and waits for its transfer; the model is updated on
  // acceptance so that the expectation is queued before the result can appear.
  task automatic send_dimension(input dimension_t d, input bit has_known, input score_t known);
    score_t predicted;
    in_valid          <= 1'b1;
    in_x_value        <= d.x_value;
    in_mean_value     <= d.mean_value;
    in_variance_value <= d.variance_value;
    in_last_element   <= d.last_element;
    do @(posedge clk); while (in_stall);
    if (score_dimension(d, predicted)) begin
      if (has_known && predicted !== known) begin
        $display("%0t: hand-typed score %h disagrees with model %h", $time, known, predicted);
        failures++;
      end
      pending_scores.push_back(has_known ? known : predicted);
    end
  endtask

  // Lowers valid for a number of cycles; zero keeps the burst going.
  task automatic sender_gap(input int cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until nothing is owed, then for the block's worst-case latency, so
  // that a dimension without a result has also finished before a write.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [47:0] value);
    cfg_wr_en           <= 1'b1;
    cfg_score_threshold <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_threshold = longint'(value);
  endtask

  function automatic logic [31:0] random_variance();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 16);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 16);
      2:       return 32'h0001_0000 + $urandom_range(0, 32'h0003_0000);
      default: return $urandom();
    endcase
  endfunction

  // Mostly means close to x so that scores stay realistic; some wide spreads
  // push the quadratic part into term and sum saturation.
  function automatic dimension_t random_dimension(input bit last);
    dimension_t d;
    d.x_value = $urandom();
    d.variance_value = random_variance();
    case ($urandom_range(0, 3))
      0:       d.mean_value = $urandom();
      1:       d.mean_value = -d.x_value;
      default: d.mean_value = d.x_value + $signed(32'($urandom_range(0, 32'h0008_0000)))
                              - 32'sh0004_0000;
    endcase
    d.last_element = last;
    return d;
  endfunction

  // Directed rows: mostly single-dimension vectors, some with known scores, and extremes.
  // With x = mean and V = 2^16/(2*pi) nearly, the term is close to zero; the
  // first row uses V = 1.0 whose score is -0.5*ln(2*pi) = -60224 (Q16.16).
  directed_row_t directed_rows[] = '{
    '{'{32'sh0, 32'sh0, 32'h0001_0000, 1'b1}, 1'b1, '{-48'sd60224, 1'b0, 1'b0}},
    '{'{32'sh0, 32'sh0, 32'h0000_0000, 1'b1}, 1'b0, '0},
    '{'{32'sh0, 32'sh0, 32'h0000_0001, 1'b1}, 1'b0, '0},
    '{'{32'sh0, 32'sh0, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
    '{'{32'sh7FFF_FFFF, -32'sh8000_0000, 32'h0000_0001, 1'b1}, 1'b1,
      '{-48'sh8000_0000, 1'b0, 1'b1}},
    '{'{-32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0000_0000, 1'b1}, 1'b1,
      '{-48'sh8000_0000, 1'b0, 1'b1}},
    '{'{32'sh7FFF_FFFF, -32'sh8000_0000, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
    '{'{32'sh0001_0000, 32'sh0, 32'h0001_0000, 1'b0}, 1'b0, '0},
    '{'{32'sh0, 32'sh0001_0000, 32'h0001_0000, 1'b0}, 1'b0, '0},
    '{'{32'sh1234_5678, 32'sh1234_5678, 32'h0000_0100, 1'b1}, 1'b0, '0},
    '{'{32'sh5555_5555, -32'sh2AAA_AAAB, 32'hAAAA_AAAA, 1'b1}, 1'b0, '0},
    '{'{-32'sh0000_0001, 32'sh0, 32'h8000_0000, 1'b1}, 1'b0, '0}
  };

  // Receiver: stall pattern with its own rhythm, plus one long hold-off so
  // that the block fills and stalls its input while the sender keeps offering.
  initial begin
    int mode;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_request) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        long_hold_request = 1'b0;
      end
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 200)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, mode) != 0);
        @(posedge clk);
      end
    end
  end

  // Result checker, sampled at the edge where the transfer happens.
  always @(posedge clk) begin
    score_t got;
    score_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_log_likelihood, out_is_member, out_saturated};
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected score, expected none, actual %h", $time, got);
        failures++;
      end else begin
        want = pending_scores.pop_front();
        if (got.log_likelihood !== want.log_likelihood)
          $display("%0t: log_likelihood expected %0d actual %0d", $time,
                   want.log_likelihood, got.log_likelihood);
        if (got.is_member !== want.is_member)
          $display("%0t: is_member expected %b actual %b", $time, want.is_member, got.is_member);
        if (got.saturated !== want.saturated)
          $display("%0t: saturated expected %b actual %b", $time, want.saturated, got.saturated);
        if (got !== want) failures++;
      end
    end
  end

  // Stimulus: reset, directed rows, then random vectors under several
  // thresholds, including both extremes.
  initial begin
    logic signed [47:0] thresholds[6];
    int sent;
    int dims;
    dimension_t d;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_score_threshold = '0;
    in_valid = 1'b0;
    in_x_value = '0;
    in_mean_value = '0;
    in_variance_value = '0;
    in_last_element = 1'b0;
    failures = 0;
    stimulus_done = 1'b0;
    long_hold_request = 1'b0;
    model_sum = 0;
    model_overflow = 1'b0;
    model_threshold = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_dimension(directed_rows[i].dim, directed_rows[i].has_known, directed_rows[i].known);
    // A vector made of several saturated terms.
    for (int i = 0; i < 4; i++) begin
      d = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'h0000_0001, 1'b0};
      send_dimension(d, 1'b0, '0);
    end
    d.last_element = 1'b1;
    send_dimension(d, 1'b0, '0);
    drain_block();

    thresholds = '{-48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, -48'sd200000,
                   48'sd0, -48'sd2000000, 48'sd300000};
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_threshold(phase == 5 ? $signed(48'({$urandom(), $urandom()})) : thresholds[phase]);
      if (phase == 2) long_hold_request = 1'b1;
      while (sent < (phase + 1) * RANDOM_ITEMS / 6) begin
        dims = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        for (int j = 0; j < dims; j++) begin
          send_dimension(random_dimension(j == dims - 1), 1'b0, '0);
          sent++;
          if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 60));
        end
        if ($urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 300));
      end
      // The sender pauses until every owed score has come back.
      drain_block();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    if (failures == 0 && pending_scores.size() == 0)
      $display("tb_diagonal_gaussian_membership_test: PASS");
    else
      $display("tb_diagonal_gaussian_membership_test: FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("tb_diagonal_gaussian_membership_test: FAIL");
    $finish;
  end

endmodule
